>>> rtl/core/gne_pkg.sv
// ----------------------------------------------------------------------------
// gne_pkg
// Shared types and constants of the navigation string encoder.
// ----------------------------------------------------------------------------
package gne_pkg;

    localparam int STR_BITS  = 85;
    localparam int DATA_BITS = 84;
    localparam int OUT_BYTES = 25;
    localparam int CNT_W     = $clog2(OUT_BYTES);

    localparam logic [3:0]  STRINGS_PER_FRAME = 4'd15;
    localparam logic [3:0]  FIRST_NUMBERED    = 4'd4;
    localparam logic [11:0] FRAMES_PER_DAY    = 12'd2880;
    // floor(x / 15) = (x * 2185) >> 15 for x below 360
    localparam logic [11:0] HOUR_RECIP        = 12'd2185;

    localparam logic [29:0] TIME_MARK = 30'h3e375096;

    // byte counter codes
    localparam logic [CNT_W-1:0] BYTE_MIX   = 5'd21;
    localparam logic [CNT_W-1:0] BYTE_MARK0 = 5'd22;
    localparam logic [CNT_W-1:0] BYTE_MARK1 = 5'd23;
    localparam logic [CNT_W-1:0] BYTE_LAST  = 5'd24;

    // check rows over {word0[19:0], word1, word2}
    localparam logic [DATA_BITS-1:0] HAM_ROWS [8] = '{
        {20'haaaab, 32'h55555556, 32'haaad5b01},
        {20'hccccd, 32'h9999999b, 32'h33366d02},
        {20'h0f0f1, 32'he1e1e1e3, 32'hc3c78e04},
        {20'h0ff01, 32'hfe01fe03, 32'hfc07f008},
        {20'hf0001, 32'hfffe0003, 32'hfff80010},
        {20'h00001, 32'hfffffffc, 32'h00000020},
        {20'hffffe, 32'h00000000, 32'h00000040},
        {20'hfffff, 32'hffffffff, 32'hffffffff}
    };

    typedef struct packed {
        logic [19:0] word0;
        logic [31:0] word1;
        logic [23:0] word2_hi;
    } words_t;

endpackage

>>> rtl/core/gne_assemble.sv
// ----------------------------------------------------------------------------
// gne_assemble
// Input beat register and word assembly with time / string number insertion.
// ----------------------------------------------------------------------------
module gne_assemble (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            s_tvalid,
    output logic            s_tready,
    input  logic [95:0]     s_tdata,   // string_index, frame_index, data_high, data_low
    output logic            words_valid,
    input  logic            words_ready,
    output gne_pkg::words_t words
);

    logic        valid_reg;
    logic [3:0]  index_reg;
    logic [11:0] frame_reg;
    logic [51:0] high_reg;
    logic [23:0] low_reg;

    logic [3:0]  pos;
    logic [11:0] frame_mod;
    logic [20:0] hour_prod;
    logic [4:0]  hour;
    logic [11:0] hour_frames;
    logic [11:0] rem_full;
    logic [19:0] word0;

    assign s_tready = !valid_reg || words_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            index_reg <= s_tdata[3:0];
            frame_reg <= s_tdata[15:4];
            high_reg  <= s_tdata[67:16];
            low_reg   <= s_tdata[91:68];
        end
    end

    always_comb
    begin
        pos = (index_reg == gne_pkg::STRINGS_PER_FRAME) ? 4'd0 : index_reg;
        frame_mod = (frame_reg >= gne_pkg::FRAMES_PER_DAY) ?
                    frame_reg - gne_pkg::FRAMES_PER_DAY : frame_reg;
        hour_prod   = {12'd0, frame_mod[11:3]} * {9'd0, gne_pkg::HOUR_RECIP};
        hour        = hour_prod[19:15];
        hour_frames = {hour, 7'd0} - {4'd0, hour, 3'd0};
        rem_full    = frame_mod - hour_frames;
        word0       = high_reg[51:32];
        if (pos == 4'd0)
        begin
            word0 = word0 | {8'd0, hour, rem_full[6:0]};
        end
        else if (pos >= gne_pkg::FIRST_NUMBERED)
        begin
            word0 = word0 | {pos + 4'd1, 16'd0};
        end
    end

    assign words_valid    = valid_reg;
    assign words.word0    = word0;
    assign words.word1    = high_reg[31:0];
    assign words.word2_hi = low_reg;

endmodule

>>> rtl/core/gne_check.sv
// ----------------------------------------------------------------------------
// gne_check
// Hamming check over the assembled words; registers the full 85-bit string.
// ----------------------------------------------------------------------------
module gne_check (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          words_valid,
    output logic                          words_ready,
    input  gne_pkg::words_t               words,
    output logic                          str_valid,
    input  logic                          str_ready,
    output logic [gne_pkg::STR_BITS-1:0]  str_bits
);

    logic                             valid_reg;
    logic [gne_pkg::STR_BITS-1:0]     str_reg;
    logic [gne_pkg::DATA_BITS-1:0]    data;
    logic [7:0]                       chk;

    always_comb
    begin
        data = {words.word0, words.word1, words.word2_hi, 8'd0};
        for (int r = 0; r < 7; r++)
        begin
            chk[r] = ^(data & gne_pkg::HAM_ROWS[r]);
        end
        chk[7] = (^(data & gne_pkg::HAM_ROWS[7])) ^ (^chk[6:0]);
    end

    assign words_ready = !valid_reg || str_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (words_ready)
        begin
            valid_reg <= words_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (words_ready && words_valid)
        begin
            str_reg <= {1'b0, words.word0, words.word1, words.word2_hi, chk};
        end
    end

    assign str_valid = valid_reg;
    assign str_bits  = str_reg;

endmodule

>>> rtl/core/gne_serial.sv
// ----------------------------------------------------------------------------
// gne_serial
// Relative coding, meander expansion and time mark; one byte per beat.
// ----------------------------------------------------------------------------
module gne_serial (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          str_valid,
    output logic                          str_ready,
    input  logic [gne_pkg::STR_BITS-1:0]  str_bits,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [7:0]                    m_tdata,
    output logic                          m_tlast
);

    logic                             busy_reg;
    logic [gne_pkg::CNT_W-1:0]        cnt_reg;
    logic                             carry_reg;
    logic [gne_pkg::STR_BITS-1:0]     shift_reg;

    logic       advance;
    logic       done;
    logic       load;
    logic [3:0] coded;
    logic [7:0] chip_byte;

    assign advance   = busy_reg && m_tready;
    assign done      = advance && (cnt_reg == gne_pkg::BYTE_LAST);
    assign load      = str_valid && (!busy_reg || done);
    assign str_ready = !busy_reg || done;

    always_comb
    begin
        coded[0] = carry_reg ^ shift_reg[gne_pkg::STR_BITS-1];
        for (int i = 1; i < 4; i++)
        begin
            coded[i] = coded[i-1] ^ shift_reg[gne_pkg::STR_BITS-1-i];
        end
        case (cnt_reg)
            gne_pkg::BYTE_MIX:
                chip_byte = {coded[0], ~coded[0], gne_pkg::TIME_MARK[29:24]};
            gne_pkg::BYTE_MARK0:
                chip_byte = gne_pkg::TIME_MARK[23:16];
            gne_pkg::BYTE_MARK1:
                chip_byte = gne_pkg::TIME_MARK[15:8];
            gne_pkg::BYTE_LAST:
                chip_byte = gne_pkg::TIME_MARK[7:0];
            default:
                chip_byte = {coded[0], ~coded[0], coded[1], ~coded[1],
                             coded[2], ~coded[2], coded[3], ~coded[3]};
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            cnt_reg   <= '0;
            carry_reg <= 1'b0;
        end
        else if (load)
        begin
            busy_reg  <= 1'b1;
            cnt_reg   <= '0;
            carry_reg <= 1'b0;
        end
        else if (done)
        begin
            busy_reg <= 1'b0;
        end
        else if (advance)
        begin
            cnt_reg   <= cnt_reg + 1'b1;
            carry_reg <= coded[3];
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            shift_reg <= str_bits;
        end
        else if (advance)
        begin
            shift_reg <= {shift_reg[gne_pkg::STR_BITS-5:0], 4'd0};
        end
    end

    assign m_tvalid = busy_reg;
    assign m_tdata  = chip_byte;
    assign m_tlast  = (cnt_reg == gne_pkg::BYTE_LAST);

    a_load_starts: assert property (@(posedge clk) disable iff (!rst_n)
        load |=> busy_reg && (cnt_reg == '0) && !carry_reg)
        else $error("string load did not restart the byte count");

    a_done_idles: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !str_valid) |=> !busy_reg)
        else $error("serializer stayed busy after the last byte");

    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (cnt_reg <= gne_pkg::BYTE_LAST))
        else $error("byte count past the last byte");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && !m_tready) |=> busy_reg && $stable(cnt_reg) && $stable(carry_reg))
        else $error("serializer moved while stalled");

endmodule

>>> rtl/core/glonass_nav_string_encoder.sv
// ----------------------------------------------------------------------------
// glonass_nav_string_encoder
// Navigation string encoder: time insertion, Hamming check, relative coding,
// meander chips and time mark, sent as 25 bytes per string.
// ----------------------------------------------------------------------------
// Input stream: one beat per string (index, frame number, 76 data bits).
// Output stream: 25 beats per string, eight chips each, earliest chip in
// bit 7; tlast marks the 25th beat, whose low bits close the time mark.
// Path: an accepted input beat passes the input register and the string
// register; the serializer loads it once free and shows its first byte.
// Flow: strings leave at the pace of the output bytes; the serializer
// takes the next string in the same cycle its last byte leaves,
// and two more strings wait in the input and string registers.
// Stall: a low m_tready holds the current byte; upstream fills the two
// register stages and then drops s_tready.
// Reset: rst_n clears all valid flags and the byte counter; nothing is
// in flight afterwards and s_tready is high.
// ----------------------------------------------------------------------------
module glonass_nav_string_encoder (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [95:0] s_tdata,    // string_index[3:0], frame_index[15:4],
                                    // data_high[67:16], data_low[91:68]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,    // chip_byte[7:0]
    output logic        m_tlast     // last_byte
);

    logic                          words_valid;
    logic                          words_ready;
    gne_pkg::words_t               words;
    logic                          str_valid;
    logic                          str_ready;
    logic [gne_pkg::STR_BITS-1:0]  str_bits;

    gne_assemble u_assemble (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .words_valid (words_valid),
        .words_ready (words_ready),
        .words       (words)
    );

    gne_check u_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .words_valid (words_valid),
        .words_ready (words_ready),
        .words       (words),
        .str_valid   (str_valid),
        .str_ready   (str_ready),
        .str_bits    (str_bits)
    );

    gne_serial u_serial (
        .clk       (clk),
        .rst_n     (rst_n),
        .str_valid (str_valid),
        .str_ready (str_ready),
        .str_bits  (str_bits),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

endmodule

>>> verif/tb.sv
// ----------------------------------------------------------------------------
// tb
// Testbench for the navigation string encoder. A table of strings covers
// field extremes, position and frame wrap and time insertion; some rows carry
// typed-in chip bytes, the rest are checked against an in-bench encoder. Then
// random strings run under random gaps and stalls on both streams, including
// a long output hold-off that backs up the input and a full drain.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          CYCLE_LIMIT  = 2000000;
    localparam int          RANDOM_ITEMS = 280;
    localparam int          LONG_HOLD    = 300;
    localparam logic [29:0] SYNC_MARK    = 30'h3e375096;

    typedef struct packed {
        logic [3:0]  idx;
        logic [11:0] frm;
        logic [51:0] dh;
        logic [23:0] dl;
        logic        fixed;     // expected bytes typed into the row
        logic [7:0]  body;      // bytes 0..20 when fixed
        logic [7:0]  mix;       // byte 21 when fixed
    } nav_item_t;

    typedef struct packed {
        logic [7:0] chips;
        logic       last;
    } beat_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [95:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;
    logic        m_tlast;

    beat_t       pending_beats[$];
    beat_t       want;
    int          mismatches = 0;
    int          beats_seen = 0;
    int          cycles     = 0;
    int          stall_left = 0;
    int          hold_reqs  = 0;
    int          hold_seen  = 0;
    int          pick;
    bit          calm       = 0;

    glonass_nav_string_encoder dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    initial clk = 1'b0;
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic logic [83:0] check_row(input int r);
        case (r)
            0: check_row = {20'haaaab, 32'h55555556, 32'haaad5b01};
            1: check_row = {20'hccccd, 32'h9999999b, 32'h33366d02};
            2: check_row = {20'h0f0f1, 32'he1e1e1e3, 32'hc3c78e04};
            3: check_row = {20'h0ff01, 32'hfe01fe03, 32'hfc07f008};
            4: check_row = {20'hf0001, 32'hfffe0003, 32'hfff80010};
            5: check_row = {20'h00001, 32'hfffffffc, 32'h00000020};
            6: check_row = {20'hffffe, 32'h00000000, 32'h00000040};
            default: check_row = {20'hfffff, 32'hffffffff, 32'hffffffff};
        endcase
    endfunction

    // Builds the 85-bit string, codes it, expands to chips and queues 25 bytes.
    function automatic void encode_string(input nav_item_t it);
        logic [3:0]   pos;
        logic [11:0]  frm;
        logic [20:0]  w0;
        logic [31:0]  w1;
        logic [31:0]  w2;
        logic [7:0]   chk;
        logic [84:0]  str;
        logic [199:0] chips;
        logic         c;
        beat_t        b;
        pos = it.idx % 4'd15;
        frm = it.frm % 12'd2880;
        w0  = {1'b0, it.dh[51:32]};
        w1  = it.dh[31:0];
        w2  = {it.dl, 8'h00};
        if (pos == 4'd0)
            w0 = w0 | (21'(frm / 12'd120) << 7) | 21'(frm % 12'd120);
        else if (pos >= 4'd4)
            w0 = w0 | (21'(pos + 5'd1) << 16);
        chk = '0;
        for (int r = 0; r < 8; r++)
            chk[r] = ^({w0[19:0], w1, w2 | {24'h0, chk}} & check_row(r));
        w2  = w2 | {24'h0, chk};
        str = {w0, w1, w2};
        c   = 1'b0;
        chips = '0;
        for (int k = 0; k < 85; k++)
        begin
            c = (k == 0) ? str[84] : (c ^ str[84-k]);
            chips[199-2*k] = c;
            chips[198-2*k] = ~c;
        end
        chips[29:0] = SYNC_MARK;
        for (int k = 0; k < 25; k++)
        begin
            b.chips = chips[199-8*k -: 8];
            b.last  = (k == 24);
            pending_beats.push_back(b);
        end
    endfunction

    task automatic report_mismatch(input string what, input logic [7:0] got,
                                   input logic [7:0] exp_val);
        if (mismatches < 40)
            $display("mismatch at beat %0d: %s got %02h want %02h",
                     beats_seen, what, got, exp_val);
        mismatches++;
    endtask

    task automatic send_string(input nav_item_t it);
        int    gap;
        int    r;
        beat_t b;
        r   = $urandom_range(0, 99);
        gap = calm ? 0 : (r < 55) ? 0 : (r < 92) ? $urandom_range(1, 4)
                                                : $urandom_range(20, 60);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'h0, it.dl, it.dh, it.frm, it.idx};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        if (it.fixed)
        begin
            for (int k = 0; k < 25; k++)
            begin
                b.chips = (k < 21) ? it.body : (k == 21) ? it.mix
                        : (k == 22) ? 8'h37 : (k == 23) ? 8'h50 : 8'h96;
                b.last  = (k == 24);
                pending_beats.push_back(b);
            end
        end
        else
            encode_string(it);
    endtask

    task automatic drain;
        s_tvalid <= 1'b0;
        while (pending_beats.size() != 0)
            @(posedge clk);
    endtask

    // output side: check beats, then pick next tready
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                if (pending_beats.size() == 0)
                    report_mismatch("unexpected byte", m_tdata, 8'h00);
                else
                begin
                    want = pending_beats.pop_front();
                    if (m_tdata !== want.chips)
                        report_mismatch("tdata", m_tdata, want.chips);
                    if (m_tlast !== want.last)
                        report_mismatch("tlast", {7'h0, m_tlast}, {7'h0, want.last});
                end
                beats_seen++;
            end
            if (hold_seen != hold_reqs)
            begin
                hold_seen  = hold_reqs;
                stall_left = LONG_HOLD;
            end
            if (stall_left > 0)
            begin
                stall_left--;
                m_tready <= 1'b0;
            end
            else if (calm)
                m_tready <= 1'b1;
            else
            begin
                pick = $urandom_range(0, 99);
                if (pick < 65)
                    m_tready <= 1'b1;
                else
                begin
                    m_tready   <= 1'b0;
                    stall_left = (pick < 97) ? $urandom_range(0, 2)
                                             : $urandom_range(15, 39);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial
    begin
        nav_item_t string_table [20];
        nav_item_t it;
        rst_n    <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        m_tready <= 1'b0;
        string_table = '{
            '{4'd1,  12'd0,    52'h0,                24'h0,      1'b1, 8'h55, 8'h7e},
            '{4'd15, 12'd0,    52'h0,                24'h0,      1'b1, 8'h55, 8'h7e},
            '{4'd0,  12'd2880, 52'h0,                24'h0,      1'b1, 8'h55, 8'h7e},
            '{4'd2,  12'd0,    52'h0,                24'h0,      1'b1, 8'h55, 8'h7e},
            '{4'd0,  12'd2879, 52'h0,                24'h0,      1'b0, 8'h00, 8'h00},
            '{4'd0,  12'd4095, 52'h0,                24'h0,      1'b0, 8'h00, 8'h00},
            '{4'd0,  12'd119,  52'h0,                24'h0,      1'b0, 8'h00, 8'h00},
            '{4'd0,  12'd120,  52'h0,                24'h0,      1'b0, 8'h00, 8'h00},
            '{4'd1,  12'd0,    52'hfffff_ffffffff,   24'hffffff, 1'b0, 8'h00, 8'h00},
            '{4'd3,  12'd0,    52'hfffff_ffffffff,   24'hffffff, 1'b0, 8'h00, 8'h00},
            '{4'd4,  12'd0,    52'h0,                24'h0,      1'b0, 8'h00, 8'h00},
            '{4'd4,  12'd0,    52'hfffff_ffffffff,   24'hffffff, 1'b0, 8'h00, 8'h00},
            '{4'd14, 12'd0,    52'h0,                24'h0,      1'b0, 8'h00, 8'h00},
            '{4'd14, 12'd2879, 52'hfffff_ffffffff,   24'hffffff, 1'b0, 8'h00, 8'h00},
            '{4'd15, 12'd2879, 52'hfffff_ffffffff,   24'hffffff, 1'b0, 8'h00, 8'h00},
            '{4'd5,  12'd1000, 52'haaaaa_aaaaaaaa,   24'haaaaaa, 1'b0, 8'h00, 8'h00},
            '{4'd6,  12'd2000, 52'h55555_55555555,   24'h555555, 1'b0, 8'h00, 8'h00},
            '{4'd3,  12'd0,    52'h1,                24'h1,      1'b0, 8'h00, 8'h00},
            '{4'd2,  12'd0,    52'h80000_00000000,   24'h800000, 1'b0, 8'h00, 8'h00},
            '{4'd0,  12'd1439, 52'h12345_6789abcd,   24'hfedcba, 1'b0, 8'h00, 8'h00}
        };
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (string_table[i])
            send_string(string_table[i]);

        // long output hold-off with the input kept busy, then a full drain
        calm = 1'b1;
        hold_reqs <= hold_reqs + 1;
        for (int n = 0; n < 12; n++)
        begin
            it.idx   = 4'($urandom_range(0, 15));
            it.frm   = 12'($urandom_range(0, 2879));
            it.dh    = 52'({$urandom, $urandom});
            it.dl    = 24'($urandom);
            it.fixed = 1'b0;
            it.body  = '0;
            it.mix   = '0;
            send_string(it);
        end
        drain();

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n % 40 == 0)
                calm = ($urandom_range(0, 3) == 0);
            it.idx   = 4'($urandom_range(0, 15));
            it.frm   = ($urandom_range(0, 4) == 0) ? 12'($urandom)
                                                   : 12'($urandom_range(0, 2879));
            it.dh    = 52'({$urandom, $urandom});
            it.dl    = 24'($urandom);
            it.fixed = 1'b0;
            it.body  = '0;
            it.mix   = '0;
            send_string(it);
        end

        drain();
        repeat (40) @(posedge clk);
        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

>>> filelist.f
rtl/core/gne_pkg.sv
rtl/core/gne_assemble.sv
rtl/core/gne_check.sv
rtl/core/gne_serial.sv
rtl/core/glonass_nav_string_encoder.sv
verif/tb.sv
